// ===== hw/rtl/rv32_alu_with_control_decode_top_macros.svh =====
// ----------------------------------------------------------------------------
// rv32_alu_with_control_decode_top_macros
// assertion macros for the rv32 alu block
// ----------------------------------------------------------------------------
`ifndef RV32_ALU_WITH_CONTROL_DECODE_TOP_MACROS_SVH
`define RV32_ALU_WITH_CONTROL_DECODE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RV_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond) \
        else $error("rv32 alu check failed");
`define RV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rv32 alu check failed");
`else
`define RV_ASSERT(label, cond)
`define RV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/rv32alu_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32alu_pkg
// types and opcode constants for the rv32 alu pipeline
// ----------------------------------------------------------------------------
package rv32alu_pkg;

    localparam logic [6:0] OPC_LUI   = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC = 7'b0010111;
    localparam logic [6:0] F7_ALT    = 7'b0100000;
    localparam logic [6:0] F7_MUL    = 7'b0000001;
    localparam logic [6:0] F7_REM    = 7'b0000011;
    localparam logic [4:0] SHAMT_MASK = 5'h1F;

    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_SLL = 3'b001;
    localparam logic [2:0] F3_XOR = 3'b100;
    localparam logic [2:0] F3_SR  = 3'b101;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    localparam logic [2:0] F3_BEQ  = 3'b000;
    localparam logic [2:0] F3_BNE  = 3'b001;
    localparam logic [2:0] F3_BLT  = 3'b100;
    localparam logic [2:0] F3_BGE  = 3'b101;
    localparam logic [2:0] F3_BLTU = 3'b110;
    localparam logic [2:0] F3_BGEU = 3'b111;

    localparam int DIV_STEPS = 32;

    // one pipeline slot
    typedef struct packed {
        logic        valid;
        logic        is_rem;
        logic        neg;
        logic [31:0] res;
        logic [31:0] rem;
        logic [31:0] dvd;
        logic [31:0] dsr;
    } t_stage;

endpackage

// ===== hw/rtl/rv32_alu_with_control_decode_top.sv =====
// ----------------------------------------------------------------------------
// rv32_alu_with_control_decode_top
// rv32im execute alu with built-in alu-control decode
// ----------------------------------------------------------------------------
// usage:
//   input channel: i_valid / o_stall carries one request per accepted edge:
//   the two class bits, func3, func7, major opcode, both operands and pc.
//   output channel: o_valid / i_stall returns one 32-bit result per request,
//   in request order.
//   the pipeline is one decode/execute stage (add, logic, shifts,
//   compares, lui, auipc, and the 32x32 multiply), 32 remainder stages that
//   each retire one bit of a restoring divide, and one output register that
//   applies the remainder sign.
//   throughput is one request per cycle while no held result stalls the
//   pipeline; the divide chain is fully pipelined so remainders do not slow anything down.
//   reset clears all valid bits; payload registers are left as they are.
//   when the receiver stalls a valid result the whole pipeline holds and
//   o_stall goes high the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "rv32_alu_with_control_decode_top_macros.svh"

module rv32_alu_with_control_decode_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_alu_class_hi,
    input  logic               i_alu_class_lo,
    input  logic [2:0]         i_func3,
    input  logic [6:0]         i_func7,
    input  logic [6:0]         i_major_opcode,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic [31:0]        i_pc_word,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result
);

    localparam int N = rv32alu_pkg::DIV_STEPS;

    rv32alu_pkg::t_stage r_st [0:N];
    rv32alu_pkg::t_stage n_st [0:N];
    logic                r_out_valid;
    logic [31:0]         r_out_result;
    logic [31:0]         n_out_result;
    logic                w_en;

    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [4:0]  w_sh;
    logic [31:0] w_up;
    logic [31:0] w_res;

    // whole pipeline advances unless a finished result is held
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    assign w_a  = i_operand_a;
    assign w_b  = i_operand_b;
    assign w_sh = w_b[4:0] & rv32alu_pkg::SHAMT_MASK;
    assign w_up = {w_b[19:0], 12'd0};

    // decode and execute everything except the remainder
    always_comb begin
        w_res = 32'd0;
        if (i_alu_class_hi && !i_alu_class_lo) begin
            case (i_func3)
                rv32alu_pkg::F3_ADD: begin
                    if (i_func7 == rv32alu_pkg::F7_ALT) w_res = w_a - w_b;
                    else if (i_func7 == rv32alu_pkg::F7_MUL) w_res = w_a * w_b;
                    else if (i_func7 == rv32alu_pkg::F7_REM) w_res = 32'd0;
                    else w_res = w_a + w_b;
                end
                rv32alu_pkg::F3_SLL: w_res = w_a << w_sh;
                rv32alu_pkg::F3_XOR: w_res = w_a ^ w_b;
                rv32alu_pkg::F3_SR: begin
                    if (i_func7 == rv32alu_pkg::F7_ALT) w_res = 32'($signed(w_a) >>> w_sh);
                    else w_res = w_a >> w_sh;
                end
                rv32alu_pkg::F3_OR:  w_res = w_a | w_b;
                rv32alu_pkg::F3_AND: w_res = w_a & w_b;
                default: w_res = 32'd0;
            endcase
        end else if (!i_alu_class_hi && i_alu_class_lo) begin
            case (i_func3)
                rv32alu_pkg::F3_BEQ:  w_res = {31'd0, w_a == w_b};
                rv32alu_pkg::F3_BNE:  w_res = {31'd0, w_a != w_b};
                rv32alu_pkg::F3_BLT:  w_res = {31'd0, $signed(w_a) < $signed(w_b)};
                rv32alu_pkg::F3_BGE:  w_res = {31'd0, $signed(w_a) >= $signed(w_b)};
                rv32alu_pkg::F3_BLTU: w_res = {31'd0, w_a < w_b};
                rv32alu_pkg::F3_BGEU: w_res = {31'd0, w_a >= w_b};
                default: w_res = 32'd0;
            endcase
        end else if (!i_alu_class_hi && !i_alu_class_lo) begin
            if (i_major_opcode == rv32alu_pkg::OPC_LUI) w_res = w_up;
            else if (i_major_opcode == rv32alu_pkg::OPC_AUIPC)
                w_res = i_pc_word + 32'($signed(w_up) >>> 2);
            else w_res = 32'd0;
        end else begin
            w_res = w_a + w_b;
        end
    end

    // stage 0 load and restoring divide steps on magnitudes
    always_comb begin
        logic [32:0] trial;
        n_st[0].valid  = i_valid;
        n_st[0].is_rem = i_alu_class_hi && !i_alu_class_lo
                         && (i_func3 == rv32alu_pkg::F3_ADD)
                         && (i_func7 == rv32alu_pkg::F7_REM);
        n_st[0].neg    = w_a[31];
        n_st[0].res    = w_res;
        n_st[0].rem    = 32'd0;
        n_st[0].dvd    = w_a[31] ? (32'd0 - w_a) : w_a;
        n_st[0].dsr    = w_b[31] ? (32'd0 - w_b) : w_b;
        for (int i = 0; i < N; i++) begin
            trial = {r_st[i].rem, r_st[i].dvd[31]};
            n_st[i+1] = r_st[i];
            n_st[i+1].dvd = {r_st[i].dvd[30:0], 1'b0};
            if (trial >= {1'b0, r_st[i].dsr}) n_st[i+1].rem = 32'(trial - {1'b0, r_st[i].dsr});
            else n_st[i+1].rem = trial[31:0];
        end
    end

    // remainder sign follows the dividend; divide by zero naturally yields the dividend
    assign n_out_result = !r_st[N].is_rem ? r_st[N].res
                        : (r_st[N].neg ? (32'd0 - r_st[N].rem) : r_st[N].rem);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= N; i++) begin
                r_st[i].valid <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            for (int i = 0; i <= N; i++) begin
                r_st[i] <= n_st[i];
            end
            r_out_valid  <= r_st[N].valid;
            r_out_result <= n_out_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_result;

    // a result only appears after the last divide stage held a request
    `RV_ASSERT(a_out_from_pipe, $rose(r_out_valid) |-> $past(r_st[N].valid))
    // stall is only raised by a held result
    `RV_ASSERT(a_stall_cause, o_stall |-> (r_out_valid && i_stall))
    // while held, the last divide stage does not move
    `RV_ASSERT_NEXT(a_hold_tail, !w_en, $stable(r_st[N].valid) && $stable(r_st[N].rem))
    // a request in the last stage enters the output register when enabled
    `RV_ASSERT_NEXT(a_tail_moves, w_en && r_st[N].valid, r_out_valid)

endmodule
